[rtl/cfcf_pkg.sv]
// Shared constants, types and helper functions for the CAN frame change filter.
`timescale 1ns / 1ps

package cfcf_pkg;

  // Default configuration
  localparam int SLOTS_DEF       = 6;
  localparam int FRAME_BYTES_DEF = 64;
  localparam int ENTRIES_DEF     = 14;

  // Fixed limits
  localparam int MAX_SLOTS  = 8;
  localparam int MAX_WORDS  = 8;
  localparam int CFG_REGS   = 6;
  localparam int ID_W       = 29;
  localparam int WORD_BITS  = 64;
  localparam int ENT_CALC_W = 6;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  typedef logic [ID_W-1:0] can_id_t;

  typedef enum logic [1:0] {
    VERDICT_CHANGED   = 2'd0,
    VERDICT_SAME      = 2'd1,
    VERDICT_UNKNOWN   = 2'd2,
    VERDICT_BAD_INDEX = 2'd3
  } verdict_e;

  // Sub-frame count per slot; zero marks a plain slot with one entry
  localparam logic [3:0] SUB_COUNT [MAX_SLOTS] = '{
    4'd0, 4'd0, 4'd0, 4'd1, 4'd8, 4'd2, 4'd0, 4'd0
  };

  // Id register reset values; slots without a register keep these
  localparam can_id_t ID_RESET [MAX_SLOTS] = '{
    29'h180110E4, 29'h180210E4, 29'h180310E4, 29'h180410E4,
    29'h1A0110E4, 29'h1B0110E4, 29'h0, 29'h0
  };

  // First store entry of a slot
  function automatic logic [ENT_CALC_W-1:0] slot_base(input logic [2:0] s);
    logic [ENT_CALC_W-1:0] b;
    b = '0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (k < int'(s)) begin
        b = b + ((SUB_COUNT[k] != 4'd0) ? ENT_CALC_W'(SUB_COUNT[k]) : ENT_CALC_W'(1));
      end
    end
    return b;
  endfunction

  // Reset value of byte 0 of an entry: its sub-frame index, or zero
  function automatic logic [3:0] sub_index(input logic [ENT_CALC_W-1:0] e,
                                           input int slots);
    logic [3:0]            r;
    logic [ENT_CALC_W-1:0] b;
    r = '0;
    b = '0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (k < slots && SUB_COUNT[k] != 4'd0 && e >= b &&
          e < b + ENT_CALC_W'(SUB_COUNT[k])) begin
        r = 4'(e - b + ENT_CALC_W'(1));
      end
      b = b + ((SUB_COUNT[k] != 4'd0) ? ENT_CALC_W'(SUB_COUNT[k]) : ENT_CALC_W'(1));
    end
    return r;
  endfunction

endpackage

[rtl/cfcf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cfcf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 112,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cfcf_regs.sv]
// APB register file holding the configured slot ids.
`timescale 1ns / 1ps

module cfcf_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfcf_pkg::APB_AW-1:0]  paddr,
  input  logic [cfcf_pkg::APB_DW-1:0]  pwdata,
  output logic [cfcf_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output cfcf_pkg::can_id_t            id_o [cfcf_pkg::CFG_REGS]
);

  cfcf_pkg::can_id_t id_q [cfcf_pkg::CFG_REGS];
  logic [2:0]        reg_ix;
  logic              reg_hit;
  logic              wr_en;

  assign reg_ix  = paddr[cfcf_pkg::APB_AW-1:2];
  assign reg_hit = reg_ix < 3'(cfcf_pkg::CFG_REGS);
  assign wr_en   = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;

  // Update the addressed id; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cfcf_pkg::CFG_REGS; k++) begin
        id_q[k] <= cfcf_pkg::ID_RESET[k];
      end
    end else if (wr_en) begin
      id_q[reg_ix] <= pwdata[cfcf_pkg::ID_W-1:0];
    end
  end

  // Read back the addressed id
  assign prdata = reg_hit ? cfcf_pkg::APB_DW'(id_q[reg_ix]) : '0;

  assign id_o = id_q;

endmodule

[rtl/cfcf_seq.sv]
// Sequencer with one shared 64-bit equality unit: slot match, compare and store update.
`timescale 1ns / 1ps

module cfcf_seq #(
  parameter int SLOTS       = cfcf_pkg::SLOTS_DEF,
  parameter int FRAME_BYTES = cfcf_pkg::FRAME_BYTES_DEF,
  parameter int ENTRIES     = cfcf_pkg::ENTRIES_DEF,
  parameter int ENTRY_W     = $clog2(ENTRIES),
  parameter int AW          = ENTRY_W + 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfcf_pkg::can_id_t               id_slot_i [cfcf_pkg::CFG_REGS],
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cfcf_pkg::can_id_t               can_id_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0]  data_i [cfcf_pkg::MAX_WORDS],
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            changed_o,
  output logic [3:0]                      entry_o,
  output logic [1:0]                      verdict_o,
  output logic                            ram_we_o,
  output logic [AW-1:0]                   ram_waddr_o,
  output logic [cfcf_pkg::WORD_BITS-1:0]  ram_wdata_o,
  output logic [AW-1:0]                   ram_raddr_o,
  input  logic [cfcf_pkg::WORD_BITS-1:0]  ram_rdata_i
);

  localparam int WORDS = FRAME_BYTES / 8;
  localparam int EW    = cfcf_pkg::ENT_CALC_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_READ  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  cfcf_pkg::can_id_t              can_id_q;
  logic [cfcf_pkg::WORD_BITS-1:0] data_q [cfcf_pkg::MAX_WORDS];
  logic [2:0]                     slot_q, slot_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic                           diff_q, diff_d;
  logic [EW-1:0]                  entry_q, entry_d;
  logic [3:0]                     rst_w0_q, rst_w0_d;
  logic                           rd_vld_q;
  logic [2:0]                     rd_word_q;
  logic [ENTRIES-1:0]             row_valid_q;
  logic                           row_set;
  logic                           load_in;
  logic                           out_load;
  logic                           res_changed_q, res_changed_d;
  logic [3:0]                     res_entry_q, res_entry_d;
  cfcf_pkg::verdict_e             res_verdict_q, res_verdict_d;
  logic                           out_valid_q;
  logic                           out_changed_q;
  logic [3:0]                     out_entry_q;
  cfcf_pkg::verdict_e             out_verdict_q;

  logic [cfcf_pkg::WORD_BITS-1:0] cmp_a, cmp_b;
  logic                           cmp_eq;
  cfcf_pkg::can_id_t              slot_id;
  logic [3:0]                     sub;
  logic [7:0]                     idx;
  logic                           idx_bad;
  logic [EW-1:0]                  ent_calc;
  logic                           ent_over;
  logic                           issue;
  logic                           last_cmp;
  logic [cfcf_pkg::WORD_BITS-1:0] rd_word;
  logic [ENTRY_W-1:0]             row_ix;

  assign in_stall_o = (state_q != S_IDLE);
  assign row_ix     = entry_q[ENTRY_W-1:0];

  // Id of the slot under test; slots without a register keep their reset id
  assign slot_id = (slot_q < 3'(cfcf_pkg::CFG_REGS)) ? id_slot_i[slot_q]
                                                     : cfcf_pkg::ID_RESET[slot_q];

  // Entry selection for the matching slot
  assign sub      = cfcf_pkg::SUB_COUNT[slot_q];
  assign idx      = data_q[0][7:0];
  assign idx_bad  = (sub != 4'd0) && ((idx == 8'd0) || (idx > {4'd0, sub}));
  assign ent_calc = cfcf_pkg::slot_base(slot_q) +
                    ((sub != 4'd0) ? EW'(4'(idx[3:0] - 4'd1)) : EW'(0));
  assign ent_over = ent_calc >= EW'(ENTRIES);

  // Stored word, or its reset image for a row never written
  assign rd_word = row_valid_q[row_ix] ? ram_rdata_i :
                   ((rd_word_q == 3'd0) ? cfcf_pkg::WORD_BITS'(rst_w0_q) : '0);

  // Shared equality unit
  always_comb begin
    if (state_q == S_MATCH) begin
      cmp_a = cfcf_pkg::WORD_BITS'(can_id_q);
      cmp_b = cfcf_pkg::WORD_BITS'(slot_id);
    end else begin
      cmp_a = rd_word;
      cmp_b = data_q[rd_word_q];
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign issue    = (state_q == S_READ) && (cnt_q < 4'(WORDS));
  assign last_cmp = rd_vld_q && (rd_word_q == 3'(WORDS - 1));

  // Store port
  assign ram_raddr_o = {row_ix, cnt_q[2:0]};
  assign ram_waddr_o = {row_ix, cnt_q[2:0]};
  assign ram_wdata_o = data_q[cnt_q[2:0]];
  assign ram_we_o    = (state_q == S_WRITE);

  // Sequence one request through match, read-compare and write-back
  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    cnt_d         = cnt_q;
    diff_d        = diff_q;
    entry_d       = entry_q;
    rst_w0_d      = rst_w0_q;
    res_changed_d = res_changed_q;
    res_entry_d   = res_entry_q;
    res_verdict_d = res_verdict_q;
    row_set       = 1'b0;
    load_in       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          slot_d  = '0;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        if (cmp_eq) begin
          if (idx_bad || ent_over) begin
            res_changed_d = 1'b0;
            res_entry_d   = '0;
            res_verdict_d = cfcf_pkg::VERDICT_BAD_INDEX;
            state_d       = S_DONE;
          end else begin
            entry_d  = ent_calc;
            rst_w0_d = cfcf_pkg::sub_index(ent_calc, SLOTS);
            cnt_d    = '0;
            diff_d   = 1'b0;
            state_d  = S_READ;
          end
        end else if (slot_q == 3'(SLOTS - 1)) begin
          res_changed_d = 1'b0;
          res_entry_d   = '0;
          res_verdict_d = cfcf_pkg::VERDICT_UNKNOWN;
          state_d       = S_DONE;
        end else begin
          slot_d = slot_q + 3'd1;
        end
      end
      S_READ: begin
        if (issue) begin
          cnt_d = cnt_q + 4'd1;
        end
        if (rd_vld_q) begin
          diff_d = diff_q | !cmp_eq;
          if (last_cmp) begin
            cnt_d = '0;
            if (diff_q || !cmp_eq) begin
              state_d = S_WRITE;
            end else begin
              res_changed_d = 1'b0;
              res_entry_d   = entry_q[3:0];
              res_verdict_d = cfcf_pkg::VERDICT_SAME;
              state_d       = S_DONE;
            end
          end
        end
      end
      S_WRITE: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[2:0] == 3'(WORDS - 1)) begin
          row_set       = 1'b1;
          res_changed_d = 1'b1;
          res_entry_d   = entry_q[3:0];
          res_verdict_d = cfcf_pkg::VERDICT_CHANGED;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (row_set) begin
        row_valid_q[row_ix] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      can_id_q <= can_id_i;
      data_q   <= data_i;
    end
    slot_q        <= slot_d;
    cnt_q         <= cnt_d;
    diff_q        <= diff_d;
    entry_q       <= entry_d;
    rst_w0_q      <= rst_w0_d;
    rd_word_q     <= cnt_q[2:0];
    res_changed_q <= res_changed_d;
    res_entry_q   <= res_entry_d;
    res_verdict_q <= res_verdict_d;
    if (out_load) begin
      out_changed_q <= res_changed_q;
      out_entry_q   <= res_entry_q;
      out_verdict_q <= res_verdict_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign changed_o   = out_changed_q;
  assign entry_o     = out_entry_q;
  assign verdict_o   = out_verdict_q;

  // Write-back only touches a row inside the store
  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (entry_q < EW'(ENTRIES)))
    else $error("store write outside the configured entries");

  // Changed flag agrees with the verdict
  a_changed_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_changed_q == (out_verdict_q == cfcf_pkg::VERDICT_CHANGED)))
    else $error("changed flag disagrees with verdict");

  // Dropped frames report entry zero
  a_drop_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_verdict_q == cfcf_pkg::VERDICT_UNKNOWN ||
                     out_verdict_q == cfcf_pkg::VERDICT_BAD_INDEX))
    |-> (out_entry_q == 4'd0))
    else $error("dropped frame carries an entry");

  // Write-back runs to completion
  a_write_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> (state_q == S_WRITE || state_q == S_DONE))
    else $error("write-back interrupted");

endmodule

[rtl/can_frame_change_filter_top.sv]
// Sequence: slot match, store read and compare, write-back if changed, result output;
// a frame dropped at the slot match skips the store read and write-back.
// A new frame is taken only when idle; the shared equality unit and the store
// serialize slot compare, word compare and word write-back.
// Reset: ids load their default values and all store rows read as their reset image
// (zeros, byte 0 of sub-frame rows holds the index) through per-row valid bits; no sweep.
`timescale 1ns / 1ps

module can_frame_change_filter_top #(
  parameter int SLOTS       = cfcf_pkg::SLOTS_DEF,
  parameter int FRAME_BYTES = cfcf_pkg::FRAME_BYTES_DEF,
  parameter int ENTRIES     = cfcf_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfcf_pkg::APB_AW-1:0]    paddr,
  input  logic [cfcf_pkg::APB_DW-1:0]    pwdata,
  output logic [cfcf_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cfcf_pkg::ID_W-1:0]      can_id_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w0_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w1_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w2_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w3_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w4_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w5_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w6_i,
  input  logic [cfcf_pkg::WORD_BITS-1:0] data_w7_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           changed_o,
  output logic [3:0]                     entry_o,
  output logic [1:0]                     verdict_o
);

  localparam int ENTRY_W = $clog2(ENTRIES);
  localparam int DEPTH   = ENTRIES * cfcf_pkg::MAX_WORDS;
  localparam int AW      = ENTRY_W + 3;

  cfcf_pkg::can_id_t              id_slot [cfcf_pkg::CFG_REGS];
  logic [cfcf_pkg::WORD_BITS-1:0] data_w  [cfcf_pkg::MAX_WORDS];
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [cfcf_pkg::WORD_BITS-1:0] ram_wdata;
  logic [cfcf_pkg::WORD_BITS-1:0] ram_rdata;

  // Gather payload words
  assign data_w[0] = data_w0_i;
  assign data_w[1] = data_w1_i;
  assign data_w[2] = data_w2_i;
  assign data_w[3] = data_w3_i;
  assign data_w[4] = data_w4_i;
  assign data_w[5] = data_w5_i;
  assign data_w[6] = data_w6_i;
  assign data_w[7] = data_w7_i;

  cfcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .id_o    (id_slot)
  );

  cfcf_ram #(
    .WIDTH (cfcf_pkg::WORD_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfcf_seq #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES),
    .ENTRIES     (ENTRIES),
    .ENTRY_W     (ENTRY_W),
    .AW          (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .id_slot_i   (id_slot),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .can_id_i    (can_id_i),
    .data_i      (data_w),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .changed_o   (changed_o),
    .entry_o     (entry_o),
    .verdict_o   (verdict_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule
